/* rtl/rcl_pkg.sv */
// Shared types, character codes and helpers for the rotor command line parser.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rcl_pkg;

    localparam int BYTE_W          = 8;
    localparam int RING_DEPTH_DEF  = 128;
    localparam int MIN_LINE_LEN    = 20;
    localparam int MARK_STEP       = 6;
    localparam int NUM_ROTORS      = 4;

    typedef logic [BYTE_W-1:0] t_byte;

    // character codes
    localparam t_byte CH_NL    = 8'h0A;
    localparam t_byte CH_O     = 8'h4F;
    localparam t_byte CH_B     = 8'h42;
    localparam t_byte CH_COLON = 8'h3A;
    localparam t_byte CH_1     = 8'h31;
    localparam t_byte CH_2     = 8'h32;
    localparam t_byte CH_0     = 8'h30;
    localparam t_byte CH_9     = 8'h39;
    localparam t_byte CH_UA    = 8'h41;
    localparam t_byte CH_UF    = 8'h46;
    localparam t_byte CH_LA    = 8'h61;
    localparam t_byte CH_LF    = 8'h66;

    // rotor field order within a line
    typedef logic [1:0] t_fld;
    localparam t_fld FLD_O1 = 2'd0;
    localparam t_fld FLD_O2 = 2'd1;
    localparam t_fld FLD_B1 = 2'd2;
    localparam t_fld FLD_B2 = 2'd3;

    // hex digit value; anything that is not a hex digit counts as zero
    function automatic logic [3:0] hex_val(input t_byte c);
        logic [3:0] v;
        v = 4'h0;
        if (c >= CH_0 && c <= CH_9) begin
            v = 4'(c - CH_0);
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = 4'(c - CH_UA + 8'd10);
        end else if (c >= CH_LA && c <= CH_LF) begin
            v = 4'(c - CH_LA + 8'd10);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/rcl_if.sv */
// Valid/ready channel interfaces for the rotor command line parser.
// Depends on rcl_pkg for the byte type.
`timescale 1ns / 1ps
`default_nettype none

interface rcl_rx_if import rcl_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcl_res_if import rcl_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  line_accepted;
    t_byte rotor_o1;
    t_byte rotor_o2;
    t_byte rotor_b1;
    t_byte rotor_b2;
    logic  values_valid;

    modport source (output valid, output line_accepted, output rotor_o1, output rotor_o2,
                    output rotor_b1, output rotor_b2, output values_valid, input ready);
    modport sink   (input valid, input line_accepted, input rotor_o1, input rotor_o2,
                    input rotor_b1, input rotor_b2, input values_valid, output ready);
endinterface

`default_nettype wire

/* rtl/rotor_command_line_parser.sv */
// Rotor command line parser: byte ring store, line walker and rotor field parser.
// Depends on rcl_pkg and the channel interfaces in rcl_if.sv.
//
// Usage:
//   i_rx carries one received byte per item; o_res carries one result item per
//   newline byte (accept flag, the four held rotor values, sticky valid flag).
//   Every byte is written into a RING_DEPTH-entry ring memory. An ordinary byte
//   leaves the block in idle, so it stays ready for the next byte.
//   A newline starts a walk through the ring from the read pointer, one stored
//   byte per cycle through the registered memory read port; the parser consumes
//   each byte as it comes back, so the line is checked in the same pass. A
//   newline holds the input not ready through the walk and until its result is
//   loaded into the output register; that result is valid on o_res as the input
//   is ready again.
//   Reset clears the pointers, the held rotor values and the valid flag. The
//   ring memory itself is not cleared; the pointers never read an entry that
//   was not written.
//   A stalled receiver holds the result in the output register; the block keeps
//   taking bytes, and a later newline waits after its walk until the register
//   frees up.
`timescale 1ns / 1ps
`default_nettype none

module rotor_command_line_parser import rcl_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rcl_rx_if.sink    i_rx,
    rcl_res_if.source o_res
);

    localparam int AW = $clog2(RING_DEPTH);

    typedef logic [AW-1:0] t_addr;
    typedef logic [AW:0]   t_pos;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    // parser position within the expected line layout
    typedef enum logic [3:0] {
        P_O,
        P_1,
        P_C,
        P_SRCH,
        P_DIG,
        P_COL,
        P_HI,
        P_LO,
        P_DONE,
        P_FAIL
    } t_pst;

    function automatic t_addr wrap_inc(input t_addr p);
        return (p == t_addr'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // ring memory
    t_byte mem [RING_DEPTH];
    t_byte r_rdata;
    logic  mem_we;
    logic  rd_en;

    // control state
    t_state r_state, n_state;
    t_addr  r_wp, n_wp;
    t_addr  r_rp, n_rp;
    t_addr  r_idx, n_idx;       // next ring address to read
    t_addr  r_k, n_k;           // line position of the next read
    t_addr  r_kd, n_kd;         // line position of the data now in r_rdata
    t_addr  r_idx_d, n_idx_d;   // ring address of the data now in r_rdata
    logic   r_pend, n_pend;     // r_rdata holds a line byte
    t_pst   r_pst, n_pst;
    t_fld   r_fld, n_fld;
    t_addr  r_mark, n_mark;     // position of the last marker found
    logic [3:0] r_hi, n_hi;
    logic   r_ok, n_ok;

    logic [NUM_ROTORS-1:0][BYTE_W-1:0] r_held, n_held;
    logic   r_vflag, n_vflag;

    // output register
    logic   r_out_valid, n_out_valid;
    logic   r_out_ok, n_out_ok;
    logic [NUM_ROTORS-1:0][BYTE_W-1:0] r_out_rot, n_out_rot;
    logic   r_out_vflag, n_out_vflag;

    // per-line parsed values
    logic [NUM_ROTORS-1:0][BYTE_W-1:0] r_val;
    logic   val_we;
    t_byte  val_wd;

    logic   rx_hs;
    t_byte  d;
    logic   data_nl;
    logic   stop;
    logic   fin;
    t_addr  len;
    t_pos   srch_start;
    t_byte  mark_ch;
    t_byte  digit_ch;
    logic   line_ok;
    t_byte  b2_val;

    assign i_rx.ready = (r_state == S_IDLE);
    assign rx_hs      = i_rx.valid && i_rx.ready;
    assign mem_we     = rx_hs;

    assign d          = r_rdata;
    assign data_nl    = r_pend && (d == CH_NL);
    // walk ends at the write pointer or after RING_DEPTH-1 bytes
    assign stop       = (r_idx == r_wp) || (r_k == t_addr'(RING_DEPTH - 1));
    assign fin        = data_nl || (stop && !r_pend);
    assign len        = data_nl ? r_kd : r_k;
    assign srch_start = t_pos'(r_mark) + t_pos'(MARK_STEP);
    assign mark_ch    = (r_fld == FLD_O2) ? CH_O : CH_B;
    assign digit_ch   = (r_fld == FLD_B1) ? CH_1 : CH_2;

    // A line that ends right after the high digit of the last value still counts:
    // the missing low digit reads as zero.
    assign b2_val     = (r_pst == P_DONE) ? r_val[FLD_B2] : {r_hi, 4'h0};
    assign line_ok    = (len > t_addr'(MIN_LINE_LEN)) &&
                        ((r_pst == P_DONE) || ((r_pst == P_LO) && (r_fld == FLD_B2)));

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_idx       = r_idx;
        n_k         = r_k;
        n_kd        = r_kd;
        n_idx_d     = r_idx_d;
        n_pend      = r_pend;
        n_pst       = r_pst;
        n_fld       = r_fld;
        n_mark      = r_mark;
        n_hi        = r_hi;
        n_ok        = r_ok;
        n_held      = r_held;
        n_vflag     = r_vflag;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_rot   = r_out_rot;
        n_out_vflag = r_out_vflag;
        rd_en       = 1'b0;
        val_we      = 1'b0;
        val_wd      = {r_hi, hex_val(d)};

        // drop the result once the receiver takes it
        if (o_res.valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (rx_hs) begin
                    n_wp = wrap_inc(r_wp);
                    if (i_rx.rx_byte == CH_NL) begin
                        n_state = S_WALK;
                        n_idx   = r_rp;
                        n_k     = '0;
                        n_pend  = 1'b0;
                        n_pst   = P_O;
                        n_fld   = FLD_O1;
                        n_mark  = '0;
                    end
                end
            end

            S_WALK: begin
                n_pend = 1'b0;
                if (fin) begin
                    n_state = S_DONE;
                    n_ok    = line_ok;
                    // advance the read pointer past the newline found
                    if (data_nl) begin
                        n_rp = wrap_inc(r_idx_d);
                    end
                    if (line_ok) begin
                        n_held[FLD_O1] = r_val[FLD_O1];
                        n_held[FLD_O2] = r_val[FLD_O2];
                        n_held[FLD_B1] = r_val[FLD_B1];
                        n_held[FLD_B2] = b2_val;
                        n_vflag        = 1'b1;
                    end
                end else begin
                    // issue the next read
                    if (!stop) begin
                        rd_en   = 1'b1;
                        n_pend  = 1'b1;
                        n_kd    = r_k;
                        n_idx_d = r_idx;
                        n_idx   = wrap_inc(r_idx);
                        n_k     = r_k + 1'b1;
                    end
                    // consume the byte that came back
                    if (r_pend) begin
                        unique case (r_pst)
                            P_O:    n_pst = (d == CH_O)     ? P_1  : P_FAIL;
                            P_1:    n_pst = (d == CH_1)     ? P_C  : P_FAIL;
                            P_C:    n_pst = (d == CH_COLON) ? P_HI : P_FAIL;
                            P_SRCH: begin
                                if ((t_pos'(r_kd) >= srch_start) && (d == mark_ch)) begin
                                    n_mark = r_kd;
                                    n_pst  = P_DIG;
                                end
                            end
                            P_DIG:  n_pst = (d == digit_ch) ? P_COL : P_FAIL;
                            P_COL:  n_pst = (d == CH_COLON) ? P_HI  : P_FAIL;
                            P_HI: begin
                                n_hi  = hex_val(d);
                                n_pst = P_LO;
                            end
                            P_LO: begin
                                val_we = 1'b1;
                                if (r_fld == FLD_B2) begin
                                    n_pst = P_DONE;
                                end else begin
                                    n_fld = r_fld + 1'b1;
                                    n_pst = P_SRCH;
                                end
                            end
                            P_DONE: n_pst = P_DONE;
                            P_FAIL: n_pst = P_FAIL;
                            default: n_pst = P_FAIL;
                        endcase
                    end
                end
            end

            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_rot   = r_held;
                    n_out_vflag = r_vflag;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_pend      <= 1'b0;
            r_held      <= '0;
            r_vflag     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_pend      <= n_pend;
            r_held      <= n_held;
            r_vflag     <= n_vflag;
            r_out_valid <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_k         <= n_k;
        r_kd        <= n_kd;
        r_idx_d     <= n_idx_d;
        r_pst       <= n_pst;
        r_fld       <= n_fld;
        r_mark      <= n_mark;
        r_hi        <= n_hi;
        r_ok        <= n_ok;
        r_out_ok    <= n_out_ok;
        r_out_rot   <= n_out_rot;
        r_out_vflag <= n_out_vflag;
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val[r_fld] <= val_wd;
        end
    end

    // ring memory: write on byte accept, registered read during the walk
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= i_rx.rx_byte;
        end
        if (rd_en) begin
            r_rdata <= mem[r_idx];
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.line_accepted = r_out_ok;
    assign o_res.rotor_o1      = r_out_rot[FLD_O1];
    assign o_res.rotor_o2      = r_out_rot[FLD_O2];
    assign o_res.rotor_b1      = r_out_rot[FLD_B1];
    assign o_res.rotor_b2      = r_out_rot[FLD_B2];
    assign o_res.values_valid  = r_out_vflag;

endmodule

`default_nettype wire
